FILE: design/dlf_pkg.sv
// ============================================================================
// dlf_pkg
// Shared types, register codes and reset values for the link force pipeline.
// ============================================================================
package dlf_pkg;

  // Field widths.
  localparam int DATA_W = 32;
  localparam int GAIN_W = 31;
  localparam int STEP_W = 17;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSFER_GAIN = 2'd2;

  // Register reset values.
  localparam logic [STEP_W-1:0] TIME_STEP_RST     = 17'd1092;
  localparam logic [GAIN_W-1:0] DAMPING_GAIN_RST  = 31'd655360;
  localparam logic [GAIN_W-1:0] TRANSFER_GAIN_RST = 31'd327680;

  typedef struct packed {
    logic [STEP_W-1:0] time_step;
    logic [GAIN_W-1:0] damping_gain;
    logic [GAIN_W-1:0] transfer_gain;
  } cfg_t;

  // Link data carried alongside the square root.
  typedef struct packed {
    logic                dead;
    logic                sx;
    logic                sy;
    logic [31:0]         mx;
    logic [31:0]         my;
    logic signed [31:0]  vx;
    logic signed [31:0]  vy;
    logic signed [32:0]  ediff;
    logic [GAIN_W-1:0]   strength;
    logic [GAIN_W-1:0]   rest;
    logic [GAIN_W-1:0]   maxlen;
  } link_t;

  // Link data carried alongside the direction divider.
  typedef struct packed {
    logic                brk;
    logic                tiny;
    logic                sx;
    logic                sy;
    logic signed [31:0]  vx;
    logic signed [31:0]  vy;
    logic signed [32:0]  ediff;
    logic [GAIN_W-1:0]   strength;
    logic signed [33:0]  dmr;
  } post_t;

endpackage

FILE: design/spring_damper_link_force.sv
// ============================================================================
// spring_damper_link_force
// Damped spring force and energy transfer for one two-cell link per beat.
// ============================================================================
// The block accepts one link beat per clock while the output is not held and
// returns one result beat per link in order. Most of the pipeline depth comes
// from the bit-per-stage square root (32 stages) and the bit-per-stage
// direction divider (FRAC_BITS + 1 stages). The whole pipeline holds while a
// result waits on out_stall. Configuration is written through cfg_we,
// cfg_index and cfg_wdata; the user must write it only while no links are in
// flight, as the block does not enforce this. An unknown index is ignored.
module spring_damper_link_force #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [dlf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dlf_pkg::GAIN_W-1:0]           cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [31:0]                   in_delta_x,
  input  logic signed [31:0]                   in_delta_y,
  input  logic signed [31:0]                   in_rel_vel_x,
  input  logic signed [31:0]                   in_rel_vel_y,
  input  logic signed [31:0]                   in_energy_a,
  input  logic signed [31:0]                   in_energy_b,
  input  logic [30:0]                          in_spring_strength,
  input  logic [30:0]                          in_rest_length,
  input  logic [30:0]                          in_max_length,
  input  logic                                 in_cell_dead,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_link_break,
  output logic signed [31:0]                   out_force_x,
  output logic signed [31:0]                   out_force_y,
  output logic signed [31:0]                   out_energy_shift
);

  localparam longint unsigned EPS_VAL = ((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam logic [31:0] EPS_Q = EPS_VAL[31:0];
  localparam int LINK_W = $bits(dlf_pkg::link_t);

  logic en;

  // Configuration registers.
  dlf_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        dlf_pkg::CFG_TIME_STEP:     cfg_nxt.time_step     = cfg_wdata[dlf_pkg::STEP_W-1:0];
        dlf_pkg::CFG_DAMPING_GAIN:  cfg_nxt.damping_gain  = cfg_wdata;
        dlf_pkg::CFG_TRANSFER_GAIN: cfg_nxt.transfer_gain = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.time_step     <= dlf_pkg::TIME_STEP_RST;
      cfg_r.damping_gain  <= dlf_pkg::DAMPING_GAIN_RST;
      cfg_r.transfer_gain <= dlf_pkg::TRANSFER_GAIN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The pipeline moves unless a finished result is held by the receiver.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Stage 1: magnitudes and energy difference.
  dlf_pkg::link_t lk_nxt, lk1_r, lk2_r, lk3_r;
  logic           v1_r, v2_r, v3_r;

  always_comb begin
    lk_nxt.dead     = in_cell_dead;
    lk_nxt.sx       = in_delta_x[31];
    lk_nxt.sy       = in_delta_y[31];
    lk_nxt.mx       = in_delta_x[31] ? 32'(-in_delta_x) : 32'(in_delta_x);
    lk_nxt.my       = in_delta_y[31] ? 32'(-in_delta_y) : 32'(in_delta_y);
    lk_nxt.vx       = in_rel_vel_x;
    lk_nxt.vy       = in_rel_vel_y;
    lk_nxt.ediff    = {in_energy_a[31], in_energy_a} - {in_energy_b[31], in_energy_b};
    lk_nxt.strength = in_spring_strength;
    lk_nxt.rest     = in_rest_length;
    lk_nxt.maxlen   = in_max_length;
  end

  // Stage 2: squares. Stage 3: sum of squares.
  logic [63:0] sqx2_r, sqy2_r, sum3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      lk1_r  <= lk_nxt;
      sqx2_r <= 64'(lk1_r.mx) * 64'(lk1_r.mx);
      sqy2_r <= 64'(lk1_r.my) * 64'(lk1_r.my);
      lk2_r  <= lk1_r;
      sum3_r <= sqx2_r + sqy2_r;
      lk3_r  <= lk2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Link length.
  logic              vs;
  logic [31:0]       dlen;
  logic [LINK_W-1:0] lks_bits;
  dlf_pkg::link_t    lks;

  dlf_sqrt_pipe #(.PW(LINK_W)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .in_rad    (sum3_r),
    .in_pay    (LINK_W'(lk3_r)),
    .out_valid (vs),
    .out_root  (dlen),
    .out_pay   (lks_bits)
  );

  assign lks = dlf_pkg::link_t'(lks_bits);

  // Stage after the root: break and tiny-length checks, stretch.
  dlf_pkg::post_t post_nxt, post4_r;
  logic           v4_r;
  logic [31:0]    d4_r, mx4_r, my4_r;

  always_comb begin
    post_nxt.brk      = lks.dead || (dlen > {1'b0, lks.maxlen});
    post_nxt.tiny     = (dlen <= EPS_Q);
    post_nxt.sx       = lks.sx;
    post_nxt.sy       = lks.sy;
    post_nxt.vx       = lks.vx;
    post_nxt.vy       = lks.vy;
    post_nxt.ediff    = lks.ediff;
    post_nxt.strength = lks.strength;
    post_nxt.dmr      = {2'b00, dlen} - {3'b000, lks.rest};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      post4_r <= post_nxt;
      d4_r    <= dlen;
      mx4_r   <= lks.mx;
      my4_r   <= lks.my;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= vs;
    end
  end

  // Unit direction magnitudes.
  logic               vq;
  logic [FRAC_BITS:0] qx, qy;
  dlf_pkg::post_t     postq;

  dlf_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v4_r),
    .in_div    (d4_r),
    .in_nx     (mx4_r),
    .in_ny     (my4_r),
    .in_pay    (post4_r),
    .out_valid (vq),
    .out_qx    (qx),
    .out_qy    (qy),
    .out_pay   (postq)
  );

  // Forces, energy shift and output register.
  logic [31:0] fx, fy, es;

  dlf_force_pipe #(.FRAC_BITS(FRAC_BITS)) u_force (
    .clk              (clk),
    .rst_n            (rst_n),
    .en               (en),
    .cfg              (cfg_r),
    .in_valid         (vq),
    .in_qx            (qx),
    .in_qy            (qy),
    .in_pay           (postq),
    .out_valid        (out_valid),
    .out_link_break   (out_link_break),
    .out_force_x      (fx),
    .out_force_y      (fy),
    .out_energy_shift (es)
  );

  assign out_force_x      = $signed(fx);
  assign out_force_y      = $signed(fy);
  assign out_energy_shift = $signed(es);

endmodule

FILE: design/dlf_sqrt_pipe.sv
// ============================================================================
// dlf_sqrt_pipe
// Pipelined integer square root of a 64-bit value, one root bit per stage.
// ============================================================================
module dlf_sqrt_pipe #(
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [63:0]   in_rad,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [31:0]   out_root,
  output logic [PW-1:0] out_pay
);

  localparam int RW = 32;
  localparam int NW = 2 * RW;
  localparam int MW = RW + 2;

  logic [RW-1:0] v_r;
  logic [MW-1:0] rem_r  [RW];
  logic [RW-1:0] root_r [RW];
  logic [NW-1:0] rad_r  [RW];
  logic [PW-1:0] pay_r  [RW];

  genvar k;
  for (k = 0; k < RW; k++) begin : g_stage
    logic          pv;
    logic [MW-1:0] prem;
    logic [RW-1:0] proot;
    logic [NW-1:0] prad;
    logic [PW-1:0] ppay;
    logic [MW-1:0] rem_sh;
    logic [MW-1:0] trial;
    logic          ge;

    // Previous stage, or the pipe inputs at the first stage.
    if (k == 0) begin : g_first
      assign pv    = in_valid;
      assign prem  = '0;
      assign proot = '0;
      assign prad  = in_rad;
      assign ppay  = in_pay;
    end else begin : g_next
      assign pv    = v_r[k-1];
      assign prem  = rem_r[k-1];
      assign proot = root_r[k-1];
      assign prad  = rad_r[k-1];
      assign ppay  = pay_r[k-1];
    end

    // Bring down two radicand bits and try the next root bit.
    assign rem_sh = {prem[MW-3:0], prad[NW-1 -: 2]};
    assign trial  = {proot, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_r[k] <= {proot[RW-2:0], ge};
        rad_r[k]  <= {prad[NW-3:0], 2'b00};
        pay_r[k]  <= ppay;
      end
    end
  end

  assign out_valid = v_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_pay   = pay_r[RW-1];

endmodule

FILE: design/dlf_div_pipe.sv
// ============================================================================
// dlf_div_pipe
// Two-lane pipelined restoring divider for the unit direction, one quotient
// bit per stage, sharing one divisor.
// ============================================================================
module dlf_div_pipe #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [31:0]            in_div,
  input  logic [31:0]            in_nx,
  input  logic [31:0]            in_ny,
  input  dlf_pkg::post_t         in_pay,
  output logic                   out_valid,
  output logic [FRAC_BITS:0]     out_qx,
  output logic [FRAC_BITS:0]     out_qy,
  output dlf_pkg::post_t         out_pay
);

  localparam int QW = FRAC_BITS + 1;
  localparam int NW = 32 + FRAC_BITS;

  logic [QW-1:0]  v_r;
  logic [NW-1:0]  remx_r [QW];
  logic [NW-1:0]  remy_r [QW];
  logic [QW-1:0]  qx_r   [QW];
  logic [QW-1:0]  qy_r   [QW];
  logic [31:0]    div_r  [QW];
  dlf_pkg::post_t pay_r  [QW];

  genvar k;
  for (k = 0; k < QW; k++) begin : g_stage
    logic           pv;
    logic [NW-1:0]  premx;
    logic [NW-1:0]  premy;
    logic [QW-1:0]  pqx;
    logic [QW-1:0]  pqy;
    logic [31:0]    pdiv;
    dlf_pkg::post_t ppay;
    logic [NW-1:0]  dsh;
    logic           gex;
    logic           gey;

    if (k == 0) begin : g_first
      assign pv    = in_valid;
      assign premx = {in_nx, {FRAC_BITS{1'b0}}};
      assign premy = {in_ny, {FRAC_BITS{1'b0}}};
      assign pqx   = '0;
      assign pqy   = '0;
      assign pdiv  = in_div;
      assign ppay  = in_pay;
    end else begin : g_next
      assign pv    = v_r[k-1];
      assign premx = remx_r[k-1];
      assign premy = remy_r[k-1];
      assign pqx   = qx_r[k-1];
      assign pqy   = qy_r[k-1];
      assign pdiv  = div_r[k-1];
      assign ppay  = pay_r[k-1];
    end

    // Compare against the divisor aligned to this quotient bit.
    assign dsh = NW'(pdiv) << (FRAC_BITS - k);
    assign gex = (premx >= dsh);
    assign gey = (premy >= dsh);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        remx_r[k] <= gex ? (premx - dsh) : premx;
        remy_r[k] <= gey ? (premy - dsh) : premy;
        qx_r[k]   <= {pqx[QW-2:0], gex};
        qy_r[k]   <= {pqy[QW-2:0], gey};
        div_r[k]  <= pdiv;
        pay_r[k]  <= ppay;
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign out_qx    = qx_r[QW-1];
  assign out_qy    = qy_r[QW-1];
  assign out_pay   = pay_r[QW-1];

endmodule

FILE: design/dlf_force_pipe.sv
// ============================================================================
// dlf_force_pipe
// Spring, damping and energy products, force projection and saturation,
// ending in the output register.
// ============================================================================
module dlf_force_pipe #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  dlf_pkg::cfg_t      cfg,
  input  logic               in_valid,
  input  logic [FRAC_BITS:0] in_qx,
  input  logic [FRAC_BITS:0] in_qy,
  input  dlf_pkg::post_t     in_pay,
  output logic               out_valid,
  output logic               out_link_break,
  output logic [31:0]        out_force_x,
  output logic [31:0]        out_force_y,
  output logic [31:0]        out_energy_shift
);

  localparam int QW   = FRAC_BITS + 1;
  localparam int VPW  = 32 + QW;
  localparam int SPW  = 64 - FRAC_BITS;
  localparam int SSW  = SPW + 1;
  localparam int TW   = SSW + 1;
  localparam int E2W  = SPW + dlf_pkg::STEP_W;
  localparam int E2MW = E2W - FRAC_BITS;
  localparam int FPW  = TW + QW;
  localparam int FMW  = FPW - FRAC_BITS;
  localparam int SATW = (E2MW > FMW) ? E2MW : FMW;
  localparam logic [SATW-1:0] LIM_NEG = SATW'(64'h8000_0000);
  localparam logic [SATW-1:0] LIM_POS = SATW'(64'h7FFF_FFFF);

  // Saturate a sign and magnitude to the signed 32-bit range.
  function automatic logic [31:0] sat_mag(input logic neg, input logic [SATW-1:0] m);
    logic [31:0] res;
    if (neg) begin
      res = (m >= LIM_NEG) ? 32'h8000_0000 : -m[31:0];
    end else begin
      res = (m > LIM_POS) ? 32'h7FFF_FFFF : m[31:0];
    end
    return res;
  endfunction

  logic [5:0] v_r;

  // Stage 1: velocity, spring and first energy products.
  logic [QW-1:0]  uxm_nxt, uym_nxt;
  logic [31:0]    vxm, vym;
  logic [32:0]    dmrm, emag;
  logic [VPW-1:0] pvx_r, pvy_r;
  logic [63:0]    psp_r, pe1_r;
  logic           svx_r, svy_r, spneg1_r, eneg1_r, sx1_r, sy1_r, brk1_r;
  logic [QW-1:0]  uxm1_r, uym1_r;

  always_comb begin
    uxm_nxt = in_pay.tiny ? '0 : in_qx;
    uym_nxt = in_pay.tiny ? '0 : in_qy;
    vxm     = in_pay.vx[31] ? 32'(-in_pay.vx) : 32'(in_pay.vx);
    vym     = in_pay.vy[31] ? 32'(-in_pay.vy) : 32'(in_pay.vy);
    dmrm    = in_pay.dmr[33] ? 33'(-in_pay.dmr) : in_pay.dmr[32:0];
    emag    = in_pay.ediff[32] ? 33'(-in_pay.ediff) : 33'(in_pay.ediff);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pvx_r    <= VPW'(vxm) * VPW'(uxm_nxt);
      pvy_r    <= VPW'(vym) * VPW'(uym_nxt);
      psp_r    <= 64'(in_pay.strength) * 64'(dmrm);
      pe1_r    <= 64'(emag) * 64'(cfg.transfer_gain);
      svx_r    <= in_pay.vx[31] ^ in_pay.sx;
      svy_r    <= in_pay.vy[31] ^ in_pay.sy;
      spneg1_r <= in_pay.dmr[33];
      eneg1_r  <= in_pay.ediff[32];
      sx1_r    <= in_pay.sx;
      sy1_r    <= in_pay.sy;
      brk1_r   <= in_pay.brk;
      uxm1_r   <= uxm_nxt;
      uym1_r   <= uym_nxt;
    end
  end

  // Stage 2: dot product, signed spring term, first energy magnitude.
  logic [33:0]           tmx, tmy, dot_nxt;
  logic [SSW-1:0]        spm;
  logic [33:0]           dot2_r;
  logic signed [SSW-1:0] spring2_r;
  logic [SPW-1:0]        e1m2_r;
  logic                  eneg2_r, sx2_r, sy2_r, brk2_r;
  logic [QW-1:0]         uxm2_r, uym2_r;

  always_comb begin
    tmx     = 34'(pvx_r >> FRAC_BITS);
    tmy     = 34'(pvy_r >> FRAC_BITS);
    dot_nxt = (svx_r ? -tmx : tmx) + (svy_r ? -tmy : tmy);
    spm     = SSW'(psp_r >> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dot2_r    <= dot_nxt;
      spring2_r <= spneg1_r ? -spm : spm;
      e1m2_r    <= SPW'(pe1_r >> FRAC_BITS);
      eneg2_r   <= eneg1_r;
      sx2_r     <= sx1_r;
      sy2_r     <= sy1_r;
      brk2_r    <= brk1_r;
      uxm2_r    <= uxm1_r;
      uym2_r    <= uym1_r;
    end
  end

  // Stage 3: damping and second energy products.
  logic [32:0]           dotm;
  logic [63:0]           pd3_r;
  logic [E2W-1:0]        pe23_r;
  logic signed [SSW-1:0] spring3_r;
  logic                  dneg3_r, eneg3_r, sx3_r, sy3_r, brk3_r;
  logic [QW-1:0]         uxm3_r, uym3_r;

  assign dotm = dot2_r[33] ? 33'(-dot2_r) : dot2_r[32:0];

  always_ff @(posedge clk) begin
    if (en) begin
      pd3_r     <= 64'(dotm) * 64'(cfg.damping_gain);
      pe23_r    <= E2W'(e1m2_r) * E2W'(cfg.time_step);
      spring3_r <= spring2_r;
      dneg3_r   <= dot2_r[33];
      eneg3_r   <= eneg2_r;
      sx3_r     <= sx2_r;
      sy3_r     <= sy2_r;
      brk3_r    <= brk2_r;
      uxm3_r    <= uxm2_r;
      uym3_r    <= uym2_r;
    end
  end

  // Stage 4: total along the link and the saturated energy shift.
  logic [SSW-1:0]       dm;
  logic signed [SSW-1:0] damp;
  logic [E2MW-1:0]      e2m;
  logic signed [TW-1:0] total4_r;
  logic [31:0]          shift4_r;
  logic                 sx4_r, sy4_r, brk4_r;
  logic [QW-1:0]        uxm4_r, uym4_r;

  always_comb begin
    dm   = SSW'(pd3_r >> FRAC_BITS);
    damp = dneg3_r ? -dm : dm;
    e2m  = E2MW'(pe23_r >> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      total4_r <= TW'(spring3_r) + TW'(damp);
      shift4_r <= sat_mag(eneg3_r, SATW'(e2m));
      sx4_r    <= sx3_r;
      sy4_r    <= sy3_r;
      brk4_r   <= brk3_r;
      uxm4_r   <= uxm3_r;
      uym4_r   <= uym3_r;
    end
  end

  // Stage 5: project the total onto the direction.
  logic           tneg;
  logic [TW-1:0]  tm;
  logic [FPW-1:0] pfx5_r, pfy5_r;
  logic           fxneg5_r, fyneg5_r, brk5_r;
  logic [31:0]    shift5_r;

  always_comb begin
    tneg = total4_r[TW-1];
    tm   = tneg ? TW'(-total4_r) : TW'(total4_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pfx5_r   <= FPW'(tm) * FPW'(uxm4_r);
      pfy5_r   <= FPW'(tm) * FPW'(uym4_r);
      fxneg5_r <= (tneg == sx4_r);
      fyneg5_r <= (tneg == sy4_r);
      brk5_r   <= brk4_r;
      shift5_r <= shift4_r;
    end
  end

  // Stage 6: saturate into the output register; a broken link gives zeros.
  logic [FMW-1:0] fxm, fym;
  logic           brk_r;
  logic [31:0]    fx_r, fy_r, es_r;

  assign fxm = FMW'(pfx5_r >> FRAC_BITS);
  assign fym = FMW'(pfy5_r >> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (en) begin
      brk_r <= brk5_r;
      fx_r  <= brk5_r ? '0 : sat_mag(fxneg5_r, SATW'(fxm));
      fy_r  <= brk5_r ? '0 : sat_mag(fyneg5_r, SATW'(fym));
      es_r  <= brk5_r ? '0 : shift5_r;
    end
  end

  // Valid bits move with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  assign out_valid        = v_r[5];
  assign out_link_break   = brk_r;
  assign out_force_x      = fx_r;
  assign out_force_y      = fy_r;
  assign out_energy_shift = es_r;

endmodule

FILE: tb/sv/link_force_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// link_force_checker
// Watches the link and result channels of spring_damper_link_force, computes
// the expected force and energy shift for every accepted link beat, and
// compares each result beat field by field in arrival order.
// ============================================================================
module link_force_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [dlf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dlf_pkg::GAIN_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [31:0]            in_delta_x,
  input  logic signed [31:0]            in_delta_y,
  input  logic signed [31:0]            in_rel_vel_x,
  input  logic signed [31:0]            in_rel_vel_y,
  input  logic signed [31:0]            in_energy_a,
  input  logic signed [31:0]            in_energy_b,
  input  logic [30:0]                   in_spring_strength,
  input  logic [30:0]                   in_rest_length,
  input  logic [30:0]                   in_max_length,
  input  logic                          in_cell_dead,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_link_break,
  input  logic signed [31:0]            out_force_x,
  input  logic signed [31:0]            out_force_y,
  input  logic signed [31:0]            out_energy_shift,
  output int                            fail_count,
  output int                            pending_count,
  output int                            result_count
);

  typedef struct {
    logic              brk;
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] shift;
  } link_result_t;

  localparam logic [127:0] MAG_CAP = 128'd1 << 61;
  localparam longint EPS_Q = ((64'd1 << FRAC_BITS) + 5000) / 10000;

  link_result_t expected_links[$];
  logic [dlf_pkg::STEP_W-1:0] dt_q;
  logic [dlf_pkg::GAIN_W-1:0] damp_q;
  logic [dlf_pkg::GAIN_W-1:0] xfer_q;

  // Fixed-point product with truncation toward zero and a magnitude cap.
  function automatic longint qmul(longint a, longint b);
    logic [127:0] ma, mb, p;
    ma = a < 0 ? 128'(-a) : 128'(a);
    mb = b < 0 ? 128'(-b) : 128'(b);
    p = (ma * mb) >> FRAC_BITS;
    if (p > MAG_CAP) p = MAG_CAP;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint root_floor(logic [63:0] n);
    logic [63:0] r, b;
    r = '0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic link_result_t link_force(
      longint dx, longint dy, longint vx, longint vy, longint ea, longint eb,
      longint k, longint rest, longint maxlen, logic dead);
    link_result_t res;
    longint mx, my, d, ux, uy, total, shift;
    mx = dx < 0 ? -dx : dx;
    my = dy < 0 ? -dy : dy;
    d = root_floor(64'(mx * mx) + 64'(my * my));
    ux = 0;
    uy = 0;
    res = '{1'b1, 32'sd0, 32'sd0, 32'sd0};
    if (dead || d > maxlen) return res;
    if (d > EPS_Q) begin
      ux = (mx << FRAC_BITS) / d;
      uy = (my << FRAC_BITS) / d;
      if (dx < 0) ux = -ux;
      if (dy < 0) uy = -uy;
    end
    total = qmul(k, d - rest) + qmul(qmul(vx, ux) + qmul(vy, uy), longint'(damp_q));
    shift = qmul(qmul(ea - eb, longint'(xfer_q)), longint'(dt_q));
    res.brk = 1'b0;
    res.fx = clamp32(-qmul(total, ux));
    res.fy = clamp32(-qmul(total, uy));
    res.shift = clamp32(shift);
    return res;
  endfunction

  always @(posedge clk) begin
    link_result_t want;
    if (!rst_n) begin
      dt_q <= dlf_pkg::TIME_STEP_RST;
      damp_q <= dlf_pkg::DAMPING_GAIN_RST;
      xfer_q <= dlf_pkg::TRANSFER_GAIN_RST;
      fail_count <= 0;
      result_count <= 0;
      pending_count <= 0;
      expected_links.delete();
    end else begin
      // Register writes; unknown indexes change nothing.
      if (cfg_we) begin
        unique case (cfg_index)
          dlf_pkg::CFG_TIME_STEP: dt_q <= cfg_wdata[dlf_pkg::STEP_W-1:0];
          dlf_pkg::CFG_DAMPING_GAIN: damp_q <= cfg_wdata;
          dlf_pkg::CFG_TRANSFER_GAIN: xfer_q <= cfg_wdata;
          default: ;
        endcase
      end
      // Each accepted link beat queues its expected result.
      if (in_valid && !in_stall)
        expected_links.insert(expected_links.size(), link_force(
            longint'(in_delta_x), longint'(in_delta_y), longint'(in_rel_vel_x),
            longint'(in_rel_vel_y), longint'(in_energy_a), longint'(in_energy_b),
            longint'(in_spring_strength), longint'(in_rest_length),
            longint'(in_max_length), in_cell_dead));
      // Each accepted result beat is matched against the oldest expectation.
      if (out_valid && !out_stall) begin
        result_count <= result_count + 1;
        if (expected_links.size() == 0) begin
          $display("%0t: result beat with nothing expected", $time);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_links.pop_front();
          if (want.brk !== out_link_break || want.fx !== out_force_x ||
              want.fy !== out_force_y || want.shift !== out_energy_shift) begin
            $display("%0t: mismatch expected brk=%0b fx=%0d fy=%0d shift=%0d",
                     $time, want.brk, want.fx, want.fy, want.shift);
            $display("%0t:          actual   brk=%0b fx=%0d fy=%0d shift=%0d",
                     $time, out_link_break, out_force_x, out_force_y,
                     out_energy_shift);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_count <= expected_links.size();
    end
  end
endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Drives directed and random link beats and register settings into
// spring_damper_link_force under random idling and backpressure.
// ============================================================================
module tb_top;

  localparam int LATENCY = 59;
  localparam longint CYCLE_LIMIT = 400000;
  // An index that names no register; writes to it are ignored.
  localparam logic [dlf_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [dlf_pkg::CFG_IDX_W-1:0] cfg_index = dlf_pkg::CFG_TIME_STEP;
  logic [dlf_pkg::GAIN_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_delta_x = '0, in_delta_y = '0;
  logic signed [31:0] in_rel_vel_x = '0, in_rel_vel_y = '0;
  logic signed [31:0] in_energy_a = '0, in_energy_b = '0;
  logic [30:0] in_spring_strength = '0, in_rest_length = '0, in_max_length = '0;
  logic in_cell_dead = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_link_break;
  logic signed [31:0] out_force_x, out_force_y, out_energy_shift;
  int fail_count, pending_count, result_count;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_cycles = 0;
  longint cycle_count = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  spring_damper_link_force u_top (.*);

  link_force_checker u_chk (.*);

  // Receiver stall: random, or a long hold-off when requested.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      out_stall <= 1'b1;
      hold_cycles <= 149;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Overall cycle limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [31:0] pick32();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(200) - 100;
      3: return $urandom;
      default: return $signed($urandom) >>> $urandom_range(24, 4);
    endcase
  endfunction

  // Offers one link beat and waits until it is accepted. Valid stays high
  // afterwards so that beats can follow back to back.
  task automatic send_link(logic [31:0] dx, logic [31:0] dy, logic [31:0] vx,
                           logic [31:0] vy, logic [31:0] ea, logic [31:0] eb,
                           logic [30:0] k, logic [30:0] rest, logic [30:0] maxlen,
                           logic dead);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_delta_x <= dx;
    in_delta_y <= dy;
    in_rel_vel_x <= vx;
    in_rel_vel_y <= vy;
    in_energy_a <= ea;
    in_energy_b <= eb;
    in_spring_strength <= k;
    in_rest_length <= rest;
    in_max_length <= maxlen;
    in_cell_dead <= dead;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic random_link();
    logic [31:0] dx, dy;
    logic [30:0] maxlen;
    dx = pick32();
    dy = pick32();
    if ($urandom_range(3) != 0) begin
      // Mostly realistic links that stay intact.
      dx = $signed($urandom) >>> $urandom_range(24, 8);
      dy = $signed($urandom) >>> $urandom_range(24, 8);
      maxlen = 31'h7fffffff - 31'($urandom_range(1000));
    end else begin
      maxlen = 31'($urandom);
    end
    send_link(dx, dy, pick32(), pick32(), pick32(), pick32(), 31'($urandom),
              31'($urandom >> $urandom_range(1, 30)), maxlen,
              $urandom_range(15) == 0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_reg(logic [dlf_pkg::CFG_IDX_W-1:0] idx,
                           logic [dlf_pkg::GAIN_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(int n);
    repeat (n) random_link();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed links at reset settings.
    send_link(0, 0, 100, -100, 32'h10000, 0, 31'h10000, 31'd0, 31'd100, 1'b0);
    send_link(6, 0, 32'h7fffffff, 0, 0, 0, 31'h7fffffff, 31'd0, 31'd1000, 1'b0);
    send_link(7, 0, 32'h7fffffff, 0, 0, 0, 31'h7fffffff, 31'd0, 31'd1000, 1'b0);
    send_link(32'h30000, 32'h40000, 32'h10000, -32'sh20000, 32'h7fffffff,
              32'h80000000, 31'h20000, 31'h40000, 31'h7fffffff, 1'b0);
    send_link(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
              32'h80000000, 32'h7fffffff, 31'h7fffffff, 31'd0, 31'h7fffffff, 1'b0);
    send_link(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
              0, 0, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 1'b0);
    send_link(32'h50000, 0, 0, 0, 0, 0, 31'h10000, 31'd0, 31'h50000, 1'b0);
    send_link(32'h50000, 0, 0, 0, 0, 0, 31'h10000, 31'd0, 31'h4ffff, 1'b0);
    send_link(32'h10000, 32'h10000, 5, 5, 5, 5, 31'd5, 31'd5, 31'h7fffffff, 1'b1);
    send_link(-32'sh20000, -32'sh10000, 32'h8000, 32'h8000, -32'sh5000,
              32'h5000, 31'h18000, 31'h10000, 31'h7fffffff, 1'b0);
    drain();

    // Extreme register settings, including an ignored index.
    write_reg(dlf_pkg::CFG_TIME_STEP, 31'h10000);
    write_reg(dlf_pkg::CFG_DAMPING_GAIN, 31'h7fffffff);
    write_reg(dlf_pkg::CFG_TRANSFER_GAIN, 31'h7fffffff);
    write_reg(CFG_SPARE, 31'h0);
    send_link(32'h7fffffff, 32'h1234, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
              32'h80000000, 31'd100, 31'd0, 31'h7fffffff, 1'b0);
    send_link(32'h30000, 32'h40000, 32'h80000000, 0, 32'h10000, 0, 31'd0, 31'd0,
              31'h7fffffff, 1'b0);
    random_phase(30);
    drain();
    write_reg(dlf_pkg::CFG_TIME_STEP, 31'd0);
    write_reg(dlf_pkg::CFG_DAMPING_GAIN, 31'd0);
    write_reg(dlf_pkg::CFG_TRANSFER_GAIN, 31'd0);
    random_phase(30);
    drain();

    // Random links with the sender idling more gently than the receiver.
    write_reg(dlf_pkg::CFG_TIME_STEP, 31'($urandom_range(65536)));
    write_reg(dlf_pkg::CFG_DAMPING_GAIN, 31'($urandom));
    write_reg(dlf_pkg::CFG_TRANSFER_GAIN, 31'($urandom >> $urandom_range(1, 16)));
    send_idle_pct = 38;
    recv_idle_pct = 45;
    random_phase(110);

    // Long receiver hold-off so the pipeline fills and pushes back.
    send_idle_pct = 0;
    hold_req = hold_req + 1;
    random_phase(80);
    drain();

    // Reset register settings restored, then roles swapped.
    write_reg(dlf_pkg::CFG_TIME_STEP, 31'd1092);
    write_reg(dlf_pkg::CFG_DAMPING_GAIN, 31'd655360);
    write_reg(dlf_pkg::CFG_TRANSFER_GAIN, 31'd327680);
    send_idle_pct = 45;
    recv_idle_pct = 38;
    random_phase(80);
    drain();

    // No idling on either side.
    write_reg(dlf_pkg::CFG_TIME_STEP, 31'($urandom_range(65536)));
    write_reg(dlf_pkg::CFG_DAMPING_GAIN, 31'($urandom_range(2000000)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(80);
    drain();

    $display("Covered %0d result beats: directed extremes, breaks, tiny lengths,",
             result_count);
    $display("register extremes, random links under idling and long backpressure.");
    if (fail_count == 0 && pending_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
